/* src/fixed_point_alu_unit_macros.svh */
// Assertion macros for the fixed-point ALU checker.
`ifndef FIXED_POINT_ALU_UNIT_MACROS_SVH
`define FIXED_POINT_ALU_UNIT_MACROS_SVH

// Clocked assertion with asynchronous reset disable.
`define FPA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Implication form built on the macro above.
`define FPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	`FPA_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

/* src/fpa_pkg.sv */
// Shared types, constants and opcodes of the fixed-point ALU.
package fpa_pkg;

	localparam int FRAC_BITS = 8;
	localparam int QW        = 33;  // quotient bits produced by the divider row
	localparam int DIV_CELLS = QW;

	typedef enum logic [3:0] {
		OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_GE, OP_LE,
		OP_EQ, OP_NE, OP_INC, OP_DEC, OP_MIN, OP_MAX, OP_TO_INT, OP_FROM_INT
	} op_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	typedef struct packed {
		logic [3:0]         op;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               truth;
		logic [1:0]         status;
	} res_t;

	typedef struct packed {
		logic [3:0]         op;
		logic signed [31:0] simple;
		logic               truth;
		logic [1:0]         simple_st;
		logic signed [63:0] prod;
		logic               neg;
		logic               div0;
		logic               div_ovf;
		logic [31:0]        den;
		logic [31:0]        rem;
		logic [QW-1:0]      low;
		logic [QW-1:0]      quo;
	} pipe_t;

endpackage

/* src/fpa_front.sv */
// Input stage: simple operations, product, and divider setup.
module fpa_front
	import fpa_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  take,
	input  cmd_t  cmd,
	output logic  vld_s1,
	output pipe_t pipe_s1
);

	logic signed [31:0] a, b;
	logic signed [32:0] wsum;
	logic signed [63:0] wide;
	logic [31:0]        maga, magb;
	logic [63:0]        num;
	logic [30:0]        high;
	pipe_t              p;

	always_comb begin
		a = cmd.operand_a;
		b = cmd.operand_b;
		maga = a[31] ? 32'(-a) : 32'(a);
		magb = b[31] ? 32'(-b) : 32'(b);
		num  = 64'(maga) << FRAC_BITS;
		high = num[63:QW];
		wsum = '0;
		wide = 64'(a) <<< FRAC_BITS;

		p           = '0;
		p.op        = cmd.op;
		p.simple_st = ST_OK;
		p.prod      = a * b;
		p.neg       = a[31] ^ b[31];
		p.div0      = (b == 32'sd0);
		p.den       = magb;
		p.rem       = 32'(high);
		p.low       = num[QW-1:0];
		p.quo       = '0;
		p.div_ovf   = ({1'b0, high} >= magb);

		case (op_t'(cmd.op))
			OP_ADD: wsum = 33'(a) + 33'(b);
			OP_SUB: wsum = 33'(a) - 33'(b);
			OP_INC: wsum = 33'(a) + 33'sd1;
			OP_DEC: wsum = 33'(a) - 33'sd1;
			default: wsum = '0;
		endcase

		case (op_t'(cmd.op))
			OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
				if (wsum[32] != wsum[31]) begin
					p.simple    = wsum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
					p.simple_st = ST_OVF;
				end else begin
					p.simple = wsum[31:0];
				end
			end
			OP_GT: p.truth = (a > b);
			OP_LT: p.truth = (a < b);
			OP_GE: p.truth = (a >= b);
			OP_LE: p.truth = (a <= b);
			OP_EQ: p.truth = (a == b);
			OP_NE: p.truth = (a != b);
			OP_MIN: p.simple = (a > b) ? b : a;
			OP_MAX: p.simple = (a > b) ? a : b;
			OP_TO_INT: p.simple = a >>> FRAC_BITS;
			OP_FROM_INT: begin
				if (wide[63:31] != {33{wide[63]}}) begin
					p.simple    = wide[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
					p.simple_st = ST_OVF;
				end else begin
					p.simple = wide[31:0];
				end
			end
			default: p.simple = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		pipe_s1 <= p;
	end

endmodule

/* src/fpa_div_cell.sv */
// One restoring-division cell: one quotient bit per stage.
module fpa_div_cell
	import fpa_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vld_i,
	input  pipe_t pipe_i,
	output logic  vld_q,
	output pipe_t pipe_q
);

	logic [32:0] trial;
	logic        ge;
	pipe_t       n;

	always_comb begin
		trial = {pipe_i.rem, pipe_i.low[QW-1]};
		ge    = trial >= {1'b0, pipe_i.den};
		n     = pipe_i;
		n.rem = ge ? 32'(trial - {1'b0, pipe_i.den}) : trial[31:0];
		n.low = {pipe_i.low[QW-2:0], 1'b0};
		n.quo = {pipe_i.quo[QW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		pipe_q <= n;
	end

endmodule

/* src/fpa_back.sv */
// Output stage: rounding, saturation and result select.
module fpa_back
	import fpa_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vld_i,
	input  pipe_t pipe_i,
	output logic  vld_q,
	output res_t  res_q
);

	logic        rnd;
	logic [33:0] qr;
	logic [63:0] m, mq;
	logic        mneg;
	res_t        r;

	always_comb begin
		rnd  = {pipe_i.rem, 1'b0} >= {1'b0, pipe_i.den};
		qr   = 34'(pipe_i.quo) + 34'(rnd);
		mneg = pipe_i.prod[63];
		m    = mneg ? 64'(-pipe_i.prod) : 64'(pipe_i.prod);
		mq   = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;

		r        = '0;
		r.value  = pipe_i.simple;
		r.truth  = pipe_i.truth;
		r.status = pipe_i.simple_st;

		case (op_t'(pipe_i.op))
			OP_MUL: begin
				if (mneg && mq > 64'h8000_0000) begin
					r.value  = 32'sh8000_0000;
					r.status = ST_OVF;
				end else if (!mneg && mq > 64'h7FFF_FFFF) begin
					r.value  = 32'sh7FFF_FFFF;
					r.status = ST_OVF;
				end else begin
					r.value = mneg ? 32'(64'd0 - mq) : mq[31:0];
				end
			end
			OP_DIV: begin
				if (pipe_i.div0) begin
					r.value  = '0;
					r.status = ST_DIV0;
				end else if (pipe_i.div_ovf ||
						(pipe_i.neg && qr > 34'h0_8000_0000) ||
						(!pipe_i.neg && qr > 34'h0_7FFF_FFFF)) begin
					r.value  = pipe_i.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
					r.status = ST_OVF;
				end else begin
					r.value = pipe_i.neg ? 32'(34'd0 - qr) : qr[31:0];
				end
			end
			default: r.value = pipe_i.simple;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= r;
	end

endmodule

/* src/fixed_point_alu_unit.sv */
// Top level of the signed fixed-point ALU (32-bit word, FRAC_BITS fraction bits).
//
// Command channel: drive cmd (op, operand_a, operand_b) and raise start; the
// transfer happens at a rising edge with start high and busy low. busy stays
// low, so a new command may be transferred on every cycle.
// Result channel: result_valid is high for exactly one cycle with result
// (value, truth, status) beside it; the receiver must take it then.
// Every operation takes the same path: one input stage, a row of 33
// division cells (one quotient bit each), and one output stage. All ops walk
// the same row, so results leave in command order. Throughput is one item per cycle.
// Multiply rounds half away from zero; divide likewise, with divide by zero
// giving value 0 and status 2. Overflow saturates and gives status 1.
// Reset (arst_n low) empties the pipeline at once: in-flight commands are
// dropped and no result strobe appears until new commands come through.
// The receiver cannot stall; results are never held.
module fixed_point_alu_unit
	import fpa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic result_valid,
	output res_t result
);

	logic  vld [DIV_CELLS+1];
	pipe_t pipe [DIV_CELLS+1];

	assign busy = 1'b0;

	// Input stage: everything except multiply rounding and division finishes here.
	fpa_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (start && !busy),
		.cmd     (cmd),
		.vld_s1  (vld[0]),
		.pipe_s1 (pipe[0])
	);

	// Divider row; other ops ride along untouched.
	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
		fpa_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (vld[i]),
			.pipe_i (pipe[i]),
			.vld_q  (vld[i+1]),
			.pipe_q (pipe[i+1])
		);
	end

	fpa_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_i  (vld[DIV_CELLS]),
		.pipe_i (pipe[DIV_CELLS]),
		.vld_q  (result_valid),
		.res_q  (result)
	);

endmodule

/* src/fpa_checker.sv */
// Port-level checker for the fixed-point ALU, bound to the top level.
`include "fixed_point_alu_unit_macros.svh"

module fpa_checker
	import fpa_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic busy,
	input logic result_valid,
	input res_t result
);

	`FPA_ASSERT(a_never_busy, clk, arst_n, !busy, "busy raised")
	`FPA_ASSERT_IMP(a_status_code, clk, arst_n, result_valid, result.status != 2'd3, "bad status")
	`FPA_ASSERT_IMP(a_truth_zero, clk, arst_n, result_valid && result.truth, result.value == 32'sd0 && result.status == ST_OK, "comparison with value")
	`FPA_ASSERT_IMP(a_div0_zero, clk, arst_n, result_valid && result.status == ST_DIV0, result.value == 32'sd0 && !result.truth, "divide by zero value")

endmodule

bind fixed_point_alu_unit fpa_checker u_fpa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);
